### hw/rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants of the length-prefixed reply parser: parse
// phases, result kinds, character codes and the classified byte record.
// ----------------------------------------------------------------------------
package lpr_pkg;

   // Default width of the element length counter
   localparam int LEN_BITS_DEF = 32;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // Character codes
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   // Parse phase of the back end
   typedef enum logic [2:0] {
      PH_LEN    = 3'd0,
      PH_LEN_CR = 3'd1,
      PH_DATA   = 3'd2,
      PH_END    = 3'd3,
      PH_END_CR = 3'd4,
      PH_SEP    = 3'd5,
      PH_SEP_CR = 3'd6
   } phase_type;

   // Result kind
   typedef enum logic [2:0] {
      K_CONSUMED = 3'd0,
      K_PAYLOAD  = 3'd1,
      K_LAST     = 3'd2,
      K_EMPTY    = 3'd3,
      K_DONE     = 3'd4,
      K_NODIGIT  = 3'd5,
      K_BADEND   = 3'd6,
      K_BADSEP   = 3'd7
   } kind_type;

   // Byte with its class, as handed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       is_digit;
      logic       is_lf;
      logic       is_cr;
      logic [3:0] digit;
   } cls_type;

endpackage

### hw/rtl/lpr_if.sv
// ----------------------------------------------------------------------------
// lpr_if
// Valid/ready stream interfaces of the reply parser: the byte request
// channel and the classified result channel.
// ----------------------------------------------------------------------------
interface lpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] kind;

   modport source (output valid, output out_byte, output kind, input ready);
   modport sink   (input valid, input out_byte, input kind, output ready);
endinterface

### hw/rtl/lpr_fifo.sv
// ----------------------------------------------------------------------------
// lpr_fifo
// Short first-in first-out queue of classified bytes between the front
// and the back end. Push is refused while full.
// ----------------------------------------------------------------------------
module lpr_fifo #(
   parameter int DEPTH = lpr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  lpr_pkg::cls_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output lpr_pkg::cls_type pop_data
);
   import lpr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cls_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/lpr_front.sv
// ----------------------------------------------------------------------------
// lpr_front
// Front end: accepts request bytes while the queue has room and tags each
// one as digit, LF or CR, with its decimal digit value.
// ----------------------------------------------------------------------------
module lpr_front (
   lpr_req_if.sink          req,
   input  logic             queue_full,
   output logic             push,
   output lpr_pkg::cls_type push_data
);
   import lpr_pkg::*;

   // Accept whenever the queue can take the transfer
   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   // Classify the byte
   always_comb begin
      push_data.data     = req.in_byte;
      push_data.is_digit = (req.in_byte >= CH_ZERO) && (req.in_byte <= CH_NINE);
      push_data.is_lf    = (req.in_byte == CH_LF);
      push_data.is_cr    = (req.in_byte == CH_CR);
      push_data.digit    = req.in_byte[3:0];
   end

endmodule

### hw/rtl/lpr_back.sv
// ----------------------------------------------------------------------------
// lpr_back
// Back end: runs the parse state machine on one classified byte per cycle
// unless rsp stalls, keeps the length counter and registers the result.
// ----------------------------------------------------------------------------
module lpr_back #(
   parameter int LEN_BITS = lpr_pkg::LEN_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  lpr_pkg::cls_type item,
   output logic             item_pop,
   lpr_rsp_if.source        rsp
);
   import lpr_pkg::*;

   localparam int PROD_W = LEN_BITS + 4;

   phase_type            phase_ff, phase_in;
   logic [LEN_BITS-1:0]  count_ff, count_in;
   logic                 digit_seen_ff, digit_seen_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   kind_type             kind_ff, kind_in;

   logic [LEN_BITS-1:0]  add_base;
   logic [PROD_W-1:0]    prod;
   logic [LEN_BITS-1:0]  add_val;
   logic [LEN_BITS-1:0]  dec_val;

   // Take the next byte when the output register is free or being drained
   assign item_pop = item_valid && (!rsp_valid_ff || rsp.ready);

   // Append a decimal digit: count*10 + d, saturating at all ones
   assign add_base = (phase_ff == PH_SEP) ? '0 : count_ff;
   assign prod     = ({4'b0, add_base} << 3) + ({4'b0, add_base} << 1)
                     + PROD_W'(item.digit);
   assign add_val  = (prod[PROD_W-1:LEN_BITS] != '0) ? '1 : prod[LEN_BITS-1:0];

   // Count down payload bytes, holding at zero
   assign dec_val  = (count_ff != '0) ? count_ff - 1'b1 : '0;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_LEN: begin
            if (item.is_lf) begin
               phase_in = !digit_seen_ff ? PH_LEN :
                          (count_ff == '0) ? PH_END : PH_DATA;
            end else if (item.is_cr && !item.is_digit) begin
               phase_in = PH_LEN_CR;
            end
         end
         PH_LEN_CR: begin
            if (item.is_lf) begin
               phase_in = !digit_seen_ff ? PH_LEN :
                          (count_ff == '0) ? PH_END : PH_DATA;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_DATA: begin
            if (dec_val == '0) begin
               phase_in = PH_END;
            end
         end
         PH_END, PH_END_CR: begin
            if (item.is_lf) begin
               phase_in = PH_SEP;
            end else if (item.is_cr && phase_ff == PH_END) begin
               phase_in = PH_END_CR;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_SEP: begin
            if (item.is_cr) begin
               phase_in = PH_SEP_CR;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_SEP_CR: begin
            phase_in = PH_LEN;
         end
         default: begin
            phase_in = PH_LEN;
         end
      endcase
   end

   // Result, counter and digit flag
   always_comb begin
      kind_in       = K_CONSUMED;
      out_byte_in   = '0;
      count_in      = count_ff;
      digit_seen_in = digit_seen_ff;
      case (phase_ff)
         PH_LEN, PH_LEN_CR: begin
            if (item.is_digit && phase_ff == PH_LEN) begin
               count_in      = add_val;
               digit_seen_in = 1'b1;
            end else if (item.is_lf) begin
               digit_seen_in = 1'b0;
               if (!digit_seen_ff) begin
                  kind_in  = K_NODIGIT;
                  count_in = '0;
               end else if (count_ff == '0) begin
                  kind_in = K_EMPTY;
               end
            end
         end
         PH_DATA: begin
            out_byte_in = item.data;
            count_in    = dec_val;
            kind_in     = (dec_val == '0) ? K_LAST : K_PAYLOAD;
         end
         PH_END, PH_END_CR: begin
            if (!(item.is_lf || (item.is_cr && phase_ff == PH_END))) begin
               kind_in       = K_BADEND;
               count_in      = '0;
               digit_seen_in = 1'b0;
            end
         end
         PH_SEP: begin
            if (item.is_digit) begin
               count_in      = add_val;
               digit_seen_in = 1'b1;
            end else if (item.is_lf) begin
               kind_in       = K_DONE;
               count_in      = '0;
               digit_seen_in = 1'b0;
            end else if (!item.is_cr) begin
               kind_in       = K_BADSEP;
               count_in      = '0;
               digit_seen_in = 1'b0;
            end
         end
         PH_SEP_CR: begin
            kind_in       = item.is_lf ? K_DONE : K_BADSEP;
            count_in      = '0;
            digit_seen_in = 1'b0;
         end
         default: begin
            count_in      = '0;
            digit_seen_in = 1'b0;
         end
      endcase
   end

   // Hold the result until the receiver takes the transfer
   assign rsp_valid_in = item_pop ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         count_ff      <= '0;
         digit_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            phase_ff      <= phase_in;
            count_ff      <= count_in;
            digit_seen_ff <= digit_seen_in;
         end
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (item_pop) begin
         out_byte_ff <= out_byte_in;
         kind_ff     <= kind_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.kind     = kind_ff;

endmodule

### hw/rtl/length_prefixed_reply_parser.sv
// ----------------------------------------------------------------------------
// length_prefixed_reply_parser
// Parses a length-prefixed reply stream one byte per cycle while rsp is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one stream byte per transfer (in_byte). rsp returns exactly
//   one result per byte: kind and, for payload kinds, out_byte.
//   A message is a series of elements (decimal length line, that many
//   payload bytes, line end) closed by an empty line; LF or CR LF end lines.
//   A byte accepted on req is held in the queue, then its result is loaded
//   into the output register and shown on rsp.
//   Throughput: one byte per cycle while rsp.ready is high; the back end
//   state machine updates its phase and length counter once per byte.
//   A two-entry queue between the byte classifier and the state machine
//   lets each side stall alone; the output register keeps its result while
//   rsp.ready is low, and req.ready drops only once the queue is full.
//   Reset (synchronous, active high) empties the queue and the output
//   register and returns the parser to waiting for a length line.
//   Length values saturate at all ones of LEN_BITS.
// ----------------------------------------------------------------------------
module length_prefixed_reply_parser #(
   parameter int LEN_BITS    = lpr_pkg::LEN_BITS_DEF,
   parameter int QUEUE_DEPTH = lpr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lpr_req_if.sink   req,
   lpr_rsp_if.source rsp
);
   import lpr_pkg::*;

   logic    push;
   cls_type push_data;
   logic    queue_full;
   logic    item_valid;
   logic    item_pop;
   cls_type item;

   // Classify incoming bytes
   lpr_front u_front (
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // Decouple front and back
   lpr_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (item_pop),
      .not_empty (item_valid),
      .pop_data  (item)
   );

   // Parse and produce results
   lpr_back #(
      .LEN_BITS (LEN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp        (rsp)
   );

endmodule
